// File: hw/rtl/flar_pkg.sv
// Package for the framed link with acknowledge and resend.
// Holds operation codes, frame constants, the controller state type and the command type.
// No dependencies.
package flar_pkg;

  localparam int unsigned RxDepthDef    = 4;
  localparam int unsigned TxDepthDef    = 8;
  localparam int unsigned MaxPayloadDef = 4;
  localparam int unsigned HeadSize      = 4;

  localparam logic [7:0] StartByte = 8'h5F;
  localparam logic [7:0] EndByte   = 8'hEF;

  localparam logic [7:0] AckReset   = 8'd6;
  localparam logic [7:0] NackReset  = 8'd21;
  localparam logic [3:0] RetryReset = 4'd5;

  localparam logic [1:0] AddrAck   = 2'd0;
  localparam logic [1:0] AddrNack  = 2'd1;
  localparam logic [1:0] AddrRetry = 2'd2;

  typedef enum logic [2:0] {
    OpRxByte  = 3'd0,
    OpQueue   = 3'd1,
    OpPoll    = 3'd2,
    OpPop     = 3'd3,
    OpFlush   = 3'd4,
    OpClose   = 3'd5,
    OpNone6   = 3'd6,
    OpNone7   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KindStatus = 2'd0,
    KindByte   = 2'd1,
    KindPop    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StEmit
  } state_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;      // apply the held item to the state
    logic emit_step; // current result item taken, advance the emit index
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last; // the current result item is the final one of the item
  } status_t;

  localparam logic [4:0] TRespStart  = 5'd1;
  localparam logic [4:0] TRespStop   = 5'd2;
  localparam logic [4:0] TFrameStart = 5'd4;
  localparam logic [4:0] TFrameStop  = 5'd8;
  localparam logic [4:0] TDelay      = 5'd16;

endpackage

// File: hw/rtl/flar_if.sv
// Channel interfaces for the framed link: input items and result items.
// Depends on flar_pkg.
interface flar_in_if;
  import flar_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] rx_byte;
  logic [7:0] cmd_code;
  logic [2:0] data_len;
  logic [7:0] data_b0;
  logic [7:0] data_b1;
  logic [7:0] data_b2;
  logic [7:0] data_b3;
  modport source (output valid, operation, rx_byte, cmd_code, data_len,
                  data_b0, data_b1, data_b2, data_b3, input ready);
  modport sink (input valid, operation, rx_byte, cmd_code, data_len,
                data_b0, data_b1, data_b2, data_b3, output ready);
endinterface

interface flar_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_out;
  logic        last;
  logic        accepted;
  logic [7:0]  got_cmd;
  logic [3:0]  got_len;
  logic [31:0] got_data;
  logic        rx_pending;
  logic        tx_pending;
  logic        link_reopened;
  logic [4:0]  timer_requests;
  modport source (output valid, kind, byte_out, last, accepted, got_cmd, got_len,
                  got_data, rx_pending, tx_pending, link_reopened, timer_requests,
                  input ready);
  modport sink (input valid, kind, byte_out, last, accepted, got_cmd, got_len,
                got_data, rx_pending, tx_pending, link_reopened, timer_requests,
                output ready);
endinterface

// File: hw/rtl/framed_link_ack_retransmit.sv
// Top level of the framed link with acknowledge and resend over a half-duplex line.
// Depends on flar_pkg, flar_if, flar_ctrl and flar_dp.
//
//  Channel   Direction  Handshake      Carries
//  in_if     sink       valid/ready    operation, rx_byte, queued command
//  out_if    source     valid/ready    kind, byte_out, last, status, popped entry
//  apb       slave      psel/penable   ack_code, nack_code, max_retries
//
// An item is taken in the idle state and executed in the next cycle; its results then
// leave one per cycle while the output side is ready: a send poll that sends a frame
// gives one result per frame byte, every other item a single result.
// Reset is asynchronous and active low; it empties both rings and opens the link.
// A stall on the output side holds the current result and blocks new items.
module framed_link_ack_retransmit
  import flar_pkg::*;
#(
  parameter int unsigned RX_DEPTH    = RxDepthDef,
  parameter int unsigned TX_DEPTH    = TxDepthDef,
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  flar_in_if.sink     in_if,
  flar_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] ack_q, nack_q;
  logic [3:0] retries_q;
  cmd_t       cmd;
  status_t    status;

  // Configuration registers; words sit at byte offsets 0, 4 and 8.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_q     <= AckReset;
      nack_q    <= NackReset;
      retries_q <= RetryReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[1:0] == 2'd0) begin
        unique case (paddr[3:2])
          AddrAck:   ack_q     <= pwdata[7:0];
          AddrNack:  nack_q    <= pwdata[7:0];
          AddrRetry: retries_q <= pwdata[3:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      AddrAck:   prdata = {24'd0, ack_q};
      AddrNack:  prdata = {24'd0, nack_q};
      AddrRetry: prdata = {28'd0, retries_q};
      default:   prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  flar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  flar_dp #(
    .RX_DEPTH    (RX_DEPTH),
    .TX_DEPTH    (TX_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_take_i        (in_if.valid && in_if.ready),
    .operation_i      (in_if.operation),
    .rx_byte_i        (in_if.rx_byte),
    .cmd_code_i       (in_if.cmd_code),
    .data_len_i       (in_if.data_len),
    .data_i           ({in_if.data_b3, in_if.data_b2, in_if.data_b1, in_if.data_b0}),
    .ack_code_i       (ack_q),
    .nack_code_i      (nack_q),
    .max_retries_i    (retries_q),
    .cmd_i            (cmd),
    .status_o         (status),
    .kind_o           (out_if.kind),
    .byte_out_o       (out_if.byte_out),
    .last_o           (out_if.last),
    .accepted_o       (out_if.accepted),
    .got_cmd_o        (out_if.got_cmd),
    .got_len_o        (out_if.got_len),
    .got_data_o       (out_if.got_data),
    .rx_pending_o     (out_if.rx_pending),
    .tx_pending_o     (out_if.tx_pending),
    .link_reopened_o  (out_if.link_reopened),
    .timer_requests_o (out_if.timer_requests)
  );

endmodule

// File: hw/rtl/flar_ctrl.sv
// Controller of the framed link: takes an item, has it executed, emits its results.
// Depends on flar_pkg.
module flar_ctrl
  import flar_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_step = 1'b1;
          if (status_i.last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// File: hw/rtl/flar_dp.sv
// Datapath of the framed link: deframer, receive and transmit rings, result builder.
// Depends on flar_pkg.
module flar_dp
  import flar_pkg::*;
#(
  parameter int unsigned RX_DEPTH    = RxDepthDef,
  parameter int unsigned TX_DEPTH    = TxDepthDef,
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_take_i,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  cmd_code_i,
  input  logic [2:0]  data_len_i,
  input  logic [31:0] data_i,
  input  logic [7:0]  ack_code_i,
  input  logic [7:0]  nack_code_i,
  input  logic [3:0]  max_retries_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_out_o,
  output logic        last_o,
  output logic        accepted_o,
  output logic [7:0]  got_cmd_o,
  output logic [3:0]  got_len_o,
  output logic [31:0] got_data_o,
  output logic        rx_pending_o,
  output logic        tx_pending_o,
  output logic        link_reopened_o,
  output logic [4:0]  timer_requests_o
);

  localparam int unsigned FrameMax = MAX_PAYLOAD + HeadSize;
  localparam int unsigned RxW      = $clog2(RX_DEPTH);
  localparam int unsigned TxW      = $clog2(TX_DEPTH);
  localparam int unsigned FsW      = $clog2(FrameMax);
  localparam int unsigned PlW      = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned EmW      = $clog2(FrameMax + 1);
  localparam int unsigned PayBits  = 8 * MAX_PAYLOAD;
  localparam logic [3:0]  MaxPay4  = 4'(MAX_PAYLOAD);
  localparam logic [7:0]  FrameMax8 = 8'(FrameMax);

  // Held input item.
  logic [2:0]  op_q;
  logic [7:0]  rxb_q, cmdc_q;
  logic [2:0]  dlen_q;
  logic [31:0] data_q;

  // State.
  logic [3:0]  byte_count_q;
  logic [7:0]  expected_len_q;
  logic [7:0]  frame_store_q [FrameMax];
  logic [RxW-1:0] rx_wp_q, rx_rp_q;
  logic [TxW-1:0] tx_wp_q, tx_rp_q;
  logic [3:0]  retry_q;
  logic        link_open_q;

  // Receive ring storage.
  logic [7:0]         rx_cmd_mem  [RX_DEPTH];
  logic [3:0]         rx_len_mem  [RX_DEPTH];
  logic [PayBits-1:0] rx_data_mem [RX_DEPTH];

  // Transmit ring storage; flags are per entry and reset.
  logic [7:0]         tx_cmd_mem  [TX_DEPTH];
  logic [PlW-1:0]     tx_n_mem    [TX_DEPTH];
  logic [PayBits-1:0] tx_data_mem [TX_DEPTH];
  logic [TX_DEPTH-1:0] tx_sent_q, tx_acked_q;

  // Result registers.
  logic [1:0]  mode_q;   // KindStatus, KindByte (frame), KindPop
  logic        nack_q;   // single NACK byte
  logic [EmW-1:0] em_idx_q, em_cnt_q;
  logic [7:0]  fr_cmd_q;
  logic [PlW-1:0] fr_n_q;
  logic [PayBits-1:0] fr_data_q;
  logic        acc_q, reo_q;
  logic [4:0]  tq_q;
  logic [7:0]  g_cmd_q;
  logic [3:0]  g_len_q;
  logic [31:0] g_data_q;

  logic [RxW-1:0] rx_wp_nxt;
  logic [TxW-1:0] tx_wp_nxt;
  logic [PlW-1:0] qn;
  logic [PayBits-1:0] qdata;
  logic [7:0] bc8;

  always_comb begin
    rx_wp_nxt = rx_wp_q + 1'b1;
    tx_wp_nxt = tx_wp_q + 1'b1;
    if (RxW'(RX_DEPTH - 1) == rx_wp_q) rx_wp_nxt = '0;
    if (TxW'(TX_DEPTH - 1) == tx_wp_q) tx_wp_nxt = '0;
    qn = (4'(dlen_q) > MaxPay4) ? PlW'(MAX_PAYLOAD) : PlW'(dlen_q);
    qdata = '0;
    for (int i = 0; i < MAX_PAYLOAD; i++) begin
      if (PlW'(i) < qn) qdata[8*i +: 8] = data_q[8*((i < 4) ? i : 3) +: 8];
    end
    bc8 = {4'd0, byte_count_q} + 8'd1;
  end

  // Payload of a finished frame, taken from the stored bytes; the end byte never
  // lands in the payload range.
  logic [PayBits-1:0] rx_pay_st;
  always_comb begin
    rx_pay_st = '0;
    for (int i = 0; i < MAX_PAYLOAD; i++) begin
      if (8'(i + HeadSize) < expected_len_q) rx_pay_st[8*i +: 8] = frame_store_q[3 + i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      op_q   <= operation_i;
      rxb_q  <= rx_byte_i;
      cmdc_q <= cmd_code_i;
      dlen_q <= data_len_i;
      data_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      expected_len_q <= '0;
      rx_wp_q        <= '0;
      rx_rp_q        <= '0;
      tx_wp_q        <= '0;
      tx_rp_q        <= '0;
      retry_q        <= '0;
      link_open_q    <= 1'b1;
      tx_sent_q      <= '0;
      tx_acked_q     <= '1;
      mode_q         <= KindStatus;
      nack_q         <= 1'b0;
      em_idx_q       <= '0;
      em_cnt_q       <= '0;
      acc_q          <= 1'b0;
      reo_q          <= 1'b0;
      tq_q           <= '0;
    end else if (cmd_i.exec) begin
      mode_q   <= KindStatus;
      nack_q   <= 1'b0;
      em_idx_q <= '0;
      em_cnt_q <= EmW'(1);
      acc_q    <= 1'b0;
      reo_q    <= 1'b0;
      tq_q     <= '0;
      case (op_q)
        OpRxByte: begin
          if (byte_count_q == 4'd0) begin
            tq_q <= TDelay | TRespStop;
            if (rxb_q == StartByte) begin
              byte_count_q <= 4'd1;
              tq_q <= TDelay | TRespStop | TFrameStart;
            end else if (rxb_q == ack_code_i) begin
              retry_q <= '0;
              tx_acked_q[tx_rp_q] <= 1'b1;
              if (!link_open_q) begin
                link_open_q <= 1'b1;
                reo_q <= 1'b1;
              end
            end else if (rxb_q == nack_code_i) begin
              if (retry_q < max_retries_i) begin
                retry_q <= retry_q + 4'd1;
                tx_sent_q[tx_rp_q] <= 1'b0;
              end
            end
          end else if (byte_count_q == 4'd1) begin
            expected_len_q <= rxb_q;
            tq_q <= TDelay;
            if (rxb_q < 8'(HeadSize) || rxb_q > FrameMax8) begin
              nack_q <= 1'b1;
              byte_count_q <= '0;
              tq_q <= TDelay | TFrameStop;
            end else begin
              byte_count_q <= 4'd2;
            end
          end else if (byte_count_q >= 4'(FrameMax)) begin
            byte_count_q <= '0;
            tq_q <= TDelay | TFrameStop;
          end else begin
            byte_count_q <= byte_count_q + 4'd1;
            tq_q <= TDelay;
            if (bc8 == expected_len_q) begin
              tq_q <= TDelay | TFrameStop;
              byte_count_q <= '0;
              if (rxb_q == EndByte) begin
                if (rx_wp_nxt != rx_rp_q) rx_wp_q <= rx_wp_nxt;
              end else begin
                nack_q <= 1'b1;
              end
            end
          end
        end
        OpQueue: begin
          if (tx_wp_nxt != tx_rp_q) begin
            tx_sent_q[tx_wp_q]  <= 1'b0;
            tx_acked_q[tx_wp_q] <= 1'b0;
            tx_wp_q <= tx_wp_nxt;
            acc_q   <= 1'b1;
          end
        end
        OpPoll: begin
          if (tx_rp_q != tx_wp_q) begin
            if (tx_acked_q[tx_rp_q]) begin
              tx_rp_q <= (TxW'(TX_DEPTH - 1) == tx_rp_q) ? '0 : tx_rp_q + 1'b1;
            end else if (!tx_sent_q[tx_rp_q]) begin
              mode_q   <= KindByte;
              em_cnt_q <= EmW'(tx_n_mem[tx_rp_q]) + EmW'(4);
              tx_sent_q[tx_rp_q] <= 1'b1;
              tq_q <= TRespStart;
            end
          end
        end
        OpPop: begin
          if (rx_rp_q != rx_wp_q) begin
            mode_q  <= KindPop;
            rx_rp_q <= (RxW'(RX_DEPTH - 1) == rx_rp_q) ? '0 : rx_rp_q + 1'b1;
            acc_q   <= 1'b1;
            tq_q    <= TDelay;
          end
        end
        OpFlush: begin
          tx_rp_q <= tx_wp_q;
          tx_acked_q[tx_wp_q] <= 1'b1;
        end
        OpClose: link_open_q <= 1'b0;
        default: ;
      endcase
    end else if (cmd_i.emit_step) begin
      em_idx_q <= em_idx_q + 1'b1;
    end
  end

  // Payload stores and frame store, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      fr_cmd_q  <= tx_cmd_mem[tx_rp_q];
      fr_n_q    <= tx_n_mem[tx_rp_q];
      fr_data_q <= tx_data_mem[tx_rp_q];
      g_cmd_q   <= rx_cmd_mem[rx_rp_q];
      g_len_q   <= rx_len_mem[rx_rp_q];
      g_data_q  <= 32'(rx_data_mem[rx_rp_q]);
      case (op_q)
        OpRxByte: begin
          if (byte_count_q == 4'd0) begin
            if (rxb_q == StartByte) frame_store_q[0] <= rxb_q;
          end else if (byte_count_q == 4'd1) begin
            frame_store_q[1] <= rxb_q;
          end else if (byte_count_q < 4'(FrameMax)) begin
            frame_store_q[FsW'(byte_count_q)] <= rxb_q;
            if (bc8 == expected_len_q && rxb_q == EndByte && rx_wp_nxt != rx_rp_q) begin
              rx_cmd_mem[rx_wp_q]  <= frame_store_q[2];
              rx_len_mem[rx_wp_q]  <= expected_len_q[3:0];
              rx_data_mem[rx_wp_q] <= rx_pay_st;
            end
          end
        end
        OpQueue: begin
          if (tx_wp_nxt != tx_rp_q) begin
            tx_cmd_mem[tx_wp_q]  <= cmdc_q;
            tx_n_mem[tx_wp_q]    <= qn;
            tx_data_mem[tx_wp_q] <= qdata;
          end
        end
        default: ;
      endcase
    end
  end

  // Result item builder.
  always_comb begin
    kind_o     = KindStatus;
    byte_out_o = '0;
    last_o     = 1'b1;
    got_cmd_o  = '0;
    got_len_o  = '0;
    got_data_o = '0;
    if (nack_q) begin
      kind_o     = KindByte;
      byte_out_o = nack_code_i;
    end else if (mode_q == KindByte) begin
      kind_o = KindByte;
      last_o = (em_idx_q == em_cnt_q - 1'b1);
      if (em_idx_q == '0) byte_out_o = StartByte;
      else if (em_idx_q == EmW'(1)) byte_out_o = 8'(fr_n_q) + 8'(HeadSize);
      else if (em_idx_q == EmW'(2)) byte_out_o = fr_cmd_q;
      else if (last_o) byte_out_o = EndByte;
      else begin
        for (int i = 0; i < MAX_PAYLOAD; i++) begin
          if (em_idx_q == EmW'(i + 3)) byte_out_o = fr_data_q[8*i +: 8];
        end
      end
    end else if (mode_q == KindPop) begin
      kind_o     = KindPop;
      got_cmd_o  = g_cmd_q;
      got_len_o  = g_len_q;
      got_data_o = g_data_q;
    end
  end

  assign status_o.last   = last_o;
  assign accepted_o      = acc_q;
  assign rx_pending_o    = (rx_rp_q != rx_wp_q);
  assign tx_pending_o    = (tx_rp_q != tx_wp_q);
  assign link_reopened_o = reo_q;
  assign timer_requests_o = tq_q;

endmodule

// File: tb/tb_top.sv
// Testbench for the framed link with acknowledge and resend: drives items, predicts
// every result item and compares them field by field. Depends on flar_pkg, flar_if
// and framed_link_ack_retransmit.
module tb_top;
  import flar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result item, with every field at the width of the output channel.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_out;
    logic        last;
    logic        accepted;
    logic [7:0]  got_cmd;
    logic [3:0]  got_len;
    logic [31:0] got_data;
    logic        rx_pending;
    logic        tx_pending;
    logic        link_reopened;
    logic [4:0]  timer_requests;
  } link_result_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  flar_in_if  in_bus ();
  flar_out_if out_bus ();

  framed_link_ack_retransmit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_bus.sink),
    .out_if  (out_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Results still owed by the block, oldest first.
  link_result_t owed_results[$];
  int unsigned  error_count = 0;
  int unsigned  items_sent  = 0;
  bit           idling_on   = 1'b1;
  int unsigned  hold_left   = 0;

  // Shadow of the link state and of the three registers.
  logic [7:0] cfg_ack, cfg_nack;
  logic [3:0] cfg_retries;
  logic [3:0] byte_count;
  logic [7:0] frame_buf [8];
  logic [7:0] frame_len;
  logic [7:0] rx_cmd [4];
  logic [7:0] rx_len [4];
  logic [31:0] rx_data [4];
  logic [1:0] rx_wr, rx_rd;
  logic [7:0] tx_cmd [8];
  logic [7:0] tx_len [8];
  logic [7:0] tx_data [8][4];
  logic       tx_sent [8];
  logic       tx_acked [8];
  logic [2:0] tx_wr, tx_rd;
  logic [3:0] retries_used;
  logic       link_up;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit, far above the slowest correct run.
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void reset_shadow();
    cfg_ack      = AckReset;
    cfg_nack     = NackReset;
    cfg_retries  = RetryReset;
    byte_count   = '0;
    frame_len    = '0;
    rx_wr        = '0;
    rx_rd        = '0;
    tx_wr        = '0;
    tx_rd        = '0;
    retries_used = '0;
    link_up      = 1'b1;
    for (int i = 0; i < 8; i++) begin
      tx_sent[i]  = 1'b0;
      tx_acked[i] = 1'b1;
    end
  endfunction

  // Applies one accepted item to the shadow state and queues the results it causes.
  function automatic void predict_link(op_e op, logic [7:0] rxb, logic [7:0] cmd,
                                       logic [2:0] dlen, logic [7:0] b0, logic [7:0] b1,
                                       logic [7:0] b2, logic [7:0] b3);
    logic [7:0]  bytes[$];
    kind_e       kinds[$];
    logic [4:0]  tq;
    logic        reop, acc;
    logic [7:0]  g_cmd;
    logic [3:0]  g_len;
    logic [31:0] g_data;
    logic [1:0]  rx_next;
    logic [2:0]  tx_next;
    logic [7:0]  qb [4];
    int          n;
    link_result_t r;
    tq = '0; reop = 1'b0; acc = 1'b0;
    g_cmd = '0; g_len = '0; g_data = '0;
    qb[0] = b0; qb[1] = b1; qb[2] = b2; qb[3] = b3;
    case (op)
      OpRxByte: begin
        tq = TDelay;
        if (byte_count == 0) begin
          tq |= TRespStop;
          // The start byte wins over ACK and NACK codes, and ACK over NACK.
          if (rxb == StartByte) begin
            frame_buf[0] = rxb;
            byte_count = 1;
            tq |= TFrameStart;
          end else if (rxb == cfg_ack) begin
            retries_used = '0;
            tx_acked[tx_rd] = 1'b1;
            if (!link_up) begin
              link_up = 1'b1;
              reop = 1'b1;
            end
          end else if (rxb == cfg_nack) begin
            // Once the retries are used up the NACK is simply ignored.
            if (retries_used < cfg_retries) begin
              retries_used++;
              tx_sent[tx_rd] = 1'b0;
            end
          end
        end else if (byte_count == 1) begin
          frame_buf[1] = rxb;
          frame_len = rxb;
          if (rxb < HeadSize || rxb > HeadSize + 4) begin
            bytes.push_back(cfg_nack);
            kinds.push_back(KindByte);
            byte_count = 0;
            tq |= TFrameStop;
          end else begin
            byte_count = 2;
          end
        end else if (byte_count >= 8) begin
          byte_count = 0;
          tq |= TFrameStop;
        end else begin
          frame_buf[byte_count] = rxb;
          byte_count++;
          if (byte_count == frame_len) begin
            tq |= TFrameStop;
            if (rxb == EndByte) begin
              rx_next = rx_wr + 2'd1;
              // A full receive ring drops the good frame silently.
              if (rx_next != rx_rd) begin
                rx_cmd[rx_wr] = frame_buf[2];
                rx_len[rx_wr] = frame_len;
                rx_data[rx_wr] = '0;
                for (int i = 0; i < 4; i++)
                  if (i < frame_len - HeadSize) rx_data[rx_wr][8*i +: 8] = frame_buf[3+i];
                rx_wr = rx_next;
              end
            end else begin
              bytes.push_back(cfg_nack);
              kinds.push_back(KindByte);
            end
            byte_count = 0;
          end
        end
      end
      OpQueue: begin
        tx_next = tx_wr + 3'd1;
        if (tx_next != tx_rd) begin
          n = (dlen > 4) ? 4 : dlen;
          tx_cmd[tx_wr]   = cmd;
          tx_len[tx_wr]   = 8'(n + HeadSize);
          tx_sent[tx_wr]  = 1'b0;
          tx_acked[tx_wr] = 1'b0;
          for (int i = 0; i < 4; i++) tx_data[tx_wr][i] = (i < n) ? qb[i] : 8'd0;
          tx_wr = tx_next;
          acc = 1'b1;
        end
      end
      OpPoll: begin
        if (tx_rd != tx_wr) begin
          if (tx_acked[tx_rd]) begin
            tx_rd++;
          end else if (!tx_sent[tx_rd]) begin
            bytes.push_back(StartByte);
            bytes.push_back(tx_len[tx_rd]);
            bytes.push_back(tx_cmd[tx_rd]);
            for (int i = 0; i < tx_len[tx_rd] - HeadSize; i++)
              bytes.push_back(tx_data[tx_rd][i]);
            bytes.push_back(EndByte);
            for (int i = 0; i < bytes.size(); i++) kinds.push_back(KindByte);
            tx_sent[tx_rd] = 1'b1;
            tq |= TRespStart;
          end
        end
      end
      OpPop: begin
        if (rx_rd != rx_wr) begin
          g_cmd  = rx_cmd[rx_rd];
          g_len  = rx_len[rx_rd][3:0];
          g_data = rx_data[rx_rd];
          rx_rd++;
          acc = 1'b1;
          tq |= TDelay;
          bytes.push_back(8'd0);
          kinds.push_back(KindPop);
        end
      end
      OpFlush: begin
        tx_rd = tx_wr;
        tx_acked[tx_wr] = 1'b1;
      end
      OpClose: link_up = 1'b0;
      default: ;
    endcase
    if (bytes.size() == 0) begin
      bytes.push_back(8'd0);
      kinds.push_back(KindStatus);
    end
    for (int k = 0; k < bytes.size(); k++) begin
      r.kind           = kinds[k];
      r.byte_out       = bytes[k];
      r.last           = (k == bytes.size() - 1);
      r.accepted       = acc;
      r.got_cmd        = (kinds[k] == KindPop) ? g_cmd : 8'd0;
      r.got_len        = (kinds[k] == KindPop) ? g_len : 4'd0;
      r.got_data       = (kinds[k] == KindPop) ? g_data : 32'd0;
      r.rx_pending     = (rx_rd != rx_wr);
      r.tx_pending     = (tx_rd != tx_wr);
      r.link_reopened  = reop;
      r.timer_requests = tq;
      owed_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    error_count++;
  endtask

  // Result side: random stalls per item, an optional long hold-off, and the check.
  initial begin
    int unsigned  stall;
    link_result_t want;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected item", out_bus.kind, 0);
        end else begin
          want = owed_results.pop_front();
          if (out_bus.kind !== want.kind) report_mismatch("kind", out_bus.kind, want.kind);
          if (out_bus.byte_out !== want.byte_out)
            report_mismatch("byte_out", out_bus.byte_out, want.byte_out);
          if (out_bus.last !== want.last) report_mismatch("last", out_bus.last, want.last);
          if (out_bus.accepted !== want.accepted)
            report_mismatch("accepted", out_bus.accepted, want.accepted);
          if (out_bus.got_cmd !== want.got_cmd)
            report_mismatch("got_cmd", out_bus.got_cmd, want.got_cmd);
          if (out_bus.got_len !== want.got_len)
            report_mismatch("got_len", out_bus.got_len, want.got_len);
          if (out_bus.got_data !== want.got_data)
            report_mismatch("got_data", out_bus.got_data, want.got_data);
          if (out_bus.rx_pending !== want.rx_pending)
            report_mismatch("rx_pending", out_bus.rx_pending, want.rx_pending);
          if (out_bus.tx_pending !== want.tx_pending)
            report_mismatch("tx_pending", out_bus.tx_pending, want.tx_pending);
          if (out_bus.link_reopened !== want.link_reopened)
            report_mismatch("link_reopened", out_bus.link_reopened, want.link_reopened);
          if (out_bus.timer_requests !== want.timer_requests)
            report_mismatch("timer_requests", out_bus.timer_requests, want.timer_requests);
        end
        stall = idling_on ? $urandom_range(0, 7) : 0;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Offers one item after a random gap and predicts it when the block takes it.
  // Valid stays high after acceptance so back-to-back items never toggle it.
  task automatic send_item(op_e op, logic [7:0] rxb, logic [7:0] cmd, logic [2:0] dlen,
                           logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.rx_byte   <= rxb;
    in_bus.cmd_code  <= cmd;
    in_bus.data_len  <= dlen;
    in_bus.data_b0   <= b0;
    in_bus.data_b1   <= b1;
    in_bus.data_b2   <= b2;
    in_bus.data_b3   <= b3;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    predict_link(op, rxb, cmd, dlen, b0, b1, b2, b3);
    items_sent++;
  endtask

  task automatic send_rx(logic [7:0] b);
    send_item(OpRxByte, b, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_op(op_e op);
    send_item(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_queue(logic [7:0] cmd, logic [2:0] dlen);
    send_item(OpQueue, $urandom, cmd, dlen, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Feeds a received frame; the length byte and the end byte may be spoiled on purpose.
  task automatic send_frame(logic [7:0] len_byte, logic [7:0] end_byte);
    send_rx(StartByte);
    send_rx(len_byte);
    if (len_byte >= HeadSize && len_byte <= HeadSize + 4) begin
      for (int i = 2; i < len_byte - 1; i++) send_rx($urandom);
      send_rx(end_byte);
    end
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Register write with a setup and an access phase; pready is always high.
  task automatic apb_write(logic [1:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      AddrAck:   cfg_ack = value[7:0];
      AddrNack:  cfg_nack = value[7:0];
      AddrRetry: cfg_retries = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_codes(logic [7:0] ack, logic [7:0] nack, logic [3:0] retries);
    wait_idle();
    apb_write(AddrAck, {24'd0, ack});
    apb_write(AddrNack, {24'd0, nack});
    apb_write(AddrRetry, {28'd0, retries});
  endtask

  // Good frames of lengths 4, 5 and 8, a bad end byte, bad lengths, and a full receive ring.
  task automatic test_receive_frames();
    send_frame(8'd4, EndByte);
    send_frame(8'd8, EndByte);
    send_frame(8'd6, 8'h00);
    send_frame(8'd3, EndByte);
    send_frame(8'd9, EndByte);
    send_frame(8'd5, EndByte);
    send_op(OpPop);
    send_op(OpPop);
    send_op(OpPop);
    send_op(OpPop);
  endtask

  // Queueing with saturated lengths, polls, NACK resends and ACKs, flush and reopen.
  task automatic test_transmit_path();
    send_queue(8'hFF, 3'd7);
    send_queue(8'h00, 3'd0);
    send_op(OpPoll);
    send_rx(cfg_nack);
    send_op(OpPoll);
    send_rx(cfg_ack);
    send_op(OpPoll);
    send_op(OpPoll);
    send_op(OpClose);
    send_rx(cfg_ack);
    send_op(OpFlush);
    send_op(OpNone6);
    send_op(OpNone7);
    send_rx(8'hAA);
    for (int i = 0; i < 9; i++) send_queue(i, i[2:0]);
    send_op(OpFlush);
  endtask

  // NACK handling at both retry extremes, with ACK and start byte sharing codes.
  task automatic test_register_extremes();
    set_codes(8'h00, 8'hFF, 4'd0);
    send_queue($urandom, 3'd4);
    send_op(OpPoll);
    send_rx(8'hFF);
    send_op(OpPoll);
    send_rx(8'h00);
    send_op(OpPoll);
    set_codes(8'hFF, 8'h00, 4'd15);
    send_queue($urandom, 3'd1);
    send_op(OpPoll);
    for (int i = 0; i < 17; i++) send_rx(8'h00);
    send_op(OpPoll);
    set_codes(StartByte, StartByte, 4'd1);
    send_rx(StartByte);
    send_rx(8'd2);
    send_op(OpFlush);
  endtask

  // Mostly well-formed exchanges with random content, with noise mixed in.
  task automatic random_link_traffic(int unsigned count);
    int unsigned stop_at, pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick % 20 == 0) idling_on = ~idling_on;
      if (pick < 25) begin
        send_frame($urandom_range(4, 8), ($urandom_range(0, 7) == 0) ? $urandom : EndByte);
      end else if (pick < 28) begin
        send_frame($urandom, $urandom);
      end else if (pick < 38) begin
        send_rx(cfg_ack);
      end else if (pick < 45) begin
        send_rx(cfg_nack);
      end else if (pick < 60) begin
        send_queue($urandom, $urandom);
      end else if (pick < 75) begin
        send_op(OpPoll);
      end else if (pick < 86) begin
        send_op(OpPop);
      end else if (pick < 89) begin
        send_op(OpFlush);
      end else if (pick < 91) begin
        send_op(OpClose);
      end else if (pick < 93) begin
        send_op(($urandom_range(0, 1) == 0) ? OpNone6 : OpNone7);
      end else begin
        send_rx($urandom);
      end
    end
    idling_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_stall();
    wait_idle();
    hold_left = 80;
    for (int i = 0; i < 5; i++) send_queue($urandom, $urandom);
    for (int i = 0; i < 6; i++) send_op(OpPoll);
    send_rx(cfg_ack);
    send_op(OpPoll);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_bus.valid = 1'b0; in_bus.operation = OpRxByte; in_bus.rx_byte = '0;
    in_bus.cmd_code = '0; in_bus.data_len = '0; in_bus.data_b0 = '0;
    in_bus.data_b1 = '0; in_bus.data_b2 = '0; in_bus.data_b3 = '0;
    reset_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_receive_frames();
    test_transmit_path();
    random_link_traffic(50);
    test_register_extremes();
    random_link_traffic(40);
    set_codes($urandom, $urandom, $urandom);
    random_link_traffic(40);
    set_codes(AckReset, NackReset, RetryReset);
    test_output_stall();
    random_link_traffic(40);

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/flar_pkg.sv
hw/rtl/flar_if.sv
hw/rtl/flar_ctrl.sv
hw/rtl/flar_dp.sv
hw/rtl/framed_link_ack_retransmit.sv
tb/tb_top.sv
